/* rtl/core/frai_pkg.sv */
// Shared types, constants and command/status structs of the register ALU interpreter.
package frai_pkg;

    localparam int NUM_REGS   = 4;
    localparam int REG_IDX_W  = 2;
    localparam int WORD_W     = 64;
    localparam int HALF_W     = WORD_W / 2;
    localparam int IMM_W      = 32;
    localparam int CNT_W      = $clog2(WORD_W);
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 72;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [REG_IDX_W-1:0] idx_t;

    typedef enum logic [2:0] {
        OP_IN  = 3'd0,
        OP_OUT = 3'd1,
        OP_MOV = 3'd2,
        OP_ADD = 3'd3,
        OP_SUB = 3'd4,
        OP_MUL = 3'd5,
        OP_DIV = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_LL,
        MUL_LH,
        MUL_HL,
        MUL_SUM
    } mul_phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DISPATCH,
        S_MUL_LL,
        S_MUL_LH,
        S_MUL_HL,
        S_MUL_SUM,
        S_DIV_INIT,
        S_DIV_STEP,
        S_WRITE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic       latch;
        logic       read;
        mul_phase_t mul_phase;
        logic       div_init;
        logic       div_step;
        logic       write;
        logic       set_err;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        op_t  opcode;
        logic y_zero;
        logic div_last;
        logic out_free;
    } stat_t;

endpackage

/* rtl/core/frai_ctrl.sv */
// Sequencer of the register ALU interpreter: steps each instruction through the datapath.
module frai_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  frai_pkg::stat_t stat,
    output frai_pkg::cmd_t  cmd
);
    import frai_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.mul_phase = MUL_NONE;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                unique case (stat.opcode) inside
                    OP_IN, OP_MOV, OP_ADD, OP_SUB: state_next = S_WRITE;
                    OP_OUT:                        state_next = S_EMIT;
                    OP_MUL:                        state_next = S_MUL_LL;
                    OP_DIV:
                    begin
                        // divide by zero: keep destination, raise the sticky flag
                        if (stat.y_zero)
                        begin
                            cmd.set_err = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_DIV_INIT;
                        end
                    end
                    default:                       state_next = S_IDLE;
                endcase
            end
            S_MUL_LL:
            begin
                cmd.mul_phase = MUL_LL;
                state_next    = S_MUL_LH;
            end
            S_MUL_LH:
            begin
                cmd.mul_phase = MUL_LH;
                state_next    = S_MUL_HL;
            end
            S_MUL_HL:
            begin
                cmd.mul_phase = MUL_HL;
                state_next    = S_MUL_SUM;
            end
            S_MUL_SUM:
            begin
                cmd.mul_phase = MUL_SUM;
                state_next    = S_WRITE;
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = S_IDLE;
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/frai_dp.sv */
// Datapath of the register ALU interpreter: register file, shared multiplier, radix-2 divider.
module frai_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  frai_pkg::cmd_t                      cmd,
    output frai_pkg::stat_t                     stat,
    input  logic [frai_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic [frai_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [frai_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import frai_pkg::*;

    op_t              op_reg;
    logic             three_reg;
    idx_t             dest_idx_reg;
    idx_t             sa_idx_reg;
    idx_t             sb_idx_reg;
    logic [IMM_W-1:0] imm_reg;

    word_t            rf_reg [NUM_REGS];
    word_t            x_reg;
    word_t            y_reg;
    word_t            prod_reg;
    word_t            acc_reg;
    word_t            rem_reg;
    word_t            quo_reg;
    word_t            dvs_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             err_reg;

    logic             m_valid_reg;
    word_t            m_value_reg;
    logic             m_err_reg;

    idx_t                 x_addr;
    idx_t                 y_addr;
    logic [HALF_W-1:0]    mul_a;
    logic [HALF_W-1:0]    mul_b;
    logic [WORD_W:0]      trial;
    word_t                result;

    // operand addresses: OUT and two-operand arithmetic read the destination first
    always_comb
    begin
        x_addr = sa_idx_reg;
        y_addr = sb_idx_reg;
        if (op_reg == OP_OUT)
        begin
            x_addr = dest_idx_reg;
        end
        else if (!three_reg && op_reg != OP_MOV && op_reg != OP_IN)
        begin
            x_addr = dest_idx_reg;
            y_addr = sa_idx_reg;
        end
    end

    always_comb
    begin
        case (cmd.mul_phase)
            MUL_LH:
            begin
                mul_a = x_reg[HALF_W-1:0];
                mul_b = y_reg[WORD_W-1:HALF_W];
            end
            MUL_HL:
            begin
                mul_a = x_reg[WORD_W-1:HALF_W];
                mul_b = y_reg[HALF_W-1:0];
            end
            default:
            begin
                mul_a = x_reg[HALF_W-1:0];
                mul_b = y_reg[HALF_W-1:0];
            end
        endcase
    end

    assign trial = {rem_reg, quo_reg[WORD_W-1]} - {1'b0, dvs_reg};

    always_comb
    begin
        case (op_reg)
            OP_IN:   result = {{(WORD_W-IMM_W){imm_reg[IMM_W-1]}}, imm_reg};
            OP_ADD:  result = x_reg + y_reg;
            OP_SUB:  result = x_reg - y_reg;
            OP_MUL:  result = acc_reg;
            OP_DIV:  result = neg_reg ? (word_t'(0) - quo_reg) : quo_reg;
            default: result = x_reg;
        endcase
    end

    // instruction word fields
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg       <= op_t'(s_axis_tuser[2:0]);
            three_reg    <= s_axis_tuser[3];
            dest_idx_reg <= s_axis_tdata[1:0];
            sa_idx_reg   <= s_axis_tdata[3:2];
            sb_idx_reg   <= s_axis_tdata[5:4];
            imm_reg      <= s_axis_tdata[37:6];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else if (cmd.write && 32'(dest_idx_reg) < NUM_REGS)
        begin
            rf_reg[dest_idx_reg] <= result;
        end
    end

    // registered reads; an index past the file reads as zero
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            x_reg <= (32'(x_addr) < NUM_REGS) ? rf_reg[x_addr] : '0;
            y_reg <= (32'(y_addr) < NUM_REGS) ? rf_reg[y_addr] : '0;
        end
    end

    // low 64 bits of the product from three 32x32 partial products
    always_ff @(posedge clk)
    begin
        if (cmd.mul_phase != MUL_NONE)
        begin
            prod_reg <= mul_a * mul_b;
        end
        case (cmd.mul_phase) inside
            MUL_LH:
            begin
                acc_reg <= prod_reg;
            end
            MUL_HL, MUL_SUM:
            begin
                acc_reg[WORD_W-1:HALF_W] <= acc_reg[WORD_W-1:HALF_W] + prod_reg[HALF_W-1:0];
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // restoring divide on magnitudes, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            quo_reg <= x_reg[WORD_W-1] ? (word_t'(0) - x_reg) : x_reg;
            dvs_reg <= y_reg[WORD_W-1] ? (word_t'(0) - y_reg) : y_reg;
            neg_reg <= x_reg[WORD_W-1] ^ y_reg[WORD_W-1];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial[WORD_W] ? {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]}
                                     : trial[WORD_W-1:0];
            quo_reg <= {quo_reg[WORD_W-2:0], ~trial[WORD_W]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            err_reg <= 1'b0;
        end
        else
        begin
            if (cmd.div_init)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.set_err)
            begin
                err_reg <= 1'b1;
            end
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            m_value_reg <= x_reg;
            m_err_reg   <= err_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-WORD_W-1){1'b0}}, m_err_reg, m_value_reg};

    assign stat.opcode   = op_reg;
    assign stat.y_zero   = (y_reg == '0);
    assign stat.div_last = (cnt_reg == CNT_W'(WORD_W-1));
    assign stat.out_free = !m_valid_reg || m_axis_tready;

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> err_reg)
        else $error("division error flag cleared without reset");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write && op_reg == OP_DIV) |-> (y_reg != '0))
        else $error("quotient written for a zero divisor");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_valid_reg || m_axis_tready))
        else $error("output word overwritten before it was taken");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write && op_reg == OP_DIV) |-> ($past(cnt_reg) == CNT_W'(WORD_W-1)))
        else $error("quotient written before all bits were formed");

endmodule

/* rtl/core/four_register_alu_interpreter.sv */
// Top level of the four-register ALU interpreter.
// Runs one decoded instruction per input word on four signed 64-bit registers cleared
// by reset; only OUT gives an output word, carrying the register and the sticky
// divide-by-zero flag. Words are taken one at a time: IN, MOV, ADD and SUB pass read,
// dispatch and write before the next accept, OUT waits while the output register is busy,
// MUL steps three 32x32 partial products through one shared multiplier, and DIV runs
// the radix-2 divider that forms one quotient bit per cycle (a zero divisor ends at
// dispatch). The output register lets the next word be accepted while a result still
// waits downstream.
module four_register_alu_interpreter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // dest_reg[1:0], src_a_reg[3:2], src_b_reg[5:4], immediate[37:6], zero pad
    input  logic [frai_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // opcode[2:0], three_operand[3]
    input  logic [frai_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_value[63:0], div_error[64], zero pad
    output logic [frai_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import frai_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    frai_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    frai_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* sim/four_register_alu_interpreter_checker.sv */
// Channel monitor, register-file predictor and output word scoreboard.
module four_register_alu_interpreter_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    // dest_reg[1:0], src_a_reg[3:2], src_b_reg[5:4], immediate[37:6], zero pad
    input  logic [frai_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // opcode[2:0], three_operand[3]
    input  logic [frai_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_value[63:0], div_error[64], zero pad
    input  logic [frai_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output int                              mismatch_count,
    output int                              pending_count
);

    timeunit 1ns;
    timeprecision 1ps;

    import frai_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        word_t value;
        logic  div_error;
    } out_word_t;

    word_t     reg_file [NUM_REGS];
    logic      div_zero_seen;
    out_word_t out_words_due [$];
    int        out_words_seen;

    initial
    begin
        mismatch_count = 0;
        pending_count  = 0;
        out_words_seen = 0;
    end

    function automatic word_t quotient_toward_zero(input word_t num, input word_t den);
        word_t mag_num;
        word_t mag_den;
        word_t quo;
        mag_num = num[WORD_W-1] ? -num : num;
        mag_den = den[WORD_W-1] ? -den : den;
        quo     = mag_num / mag_den;
        return (num[WORD_W-1] ^ den[WORD_W-1]) ? -quo : quo;
    endfunction

    function automatic void execute_instruction(input logic [2:0] op, input logic three,
                                                input idx_t dst, input idx_t src_a,
                                                input idx_t src_b, input logic [IMM_W-1:0] imm);
        word_t     lhs;
        word_t     rhs;
        out_word_t emitted;
        lhs = three ? reg_file[src_a] : reg_file[dst];
        rhs = three ? reg_file[src_b] : reg_file[src_a];
        case (op)
            OP_IN:  reg_file[dst] = {{(WORD_W-IMM_W){imm[IMM_W-1]}}, imm};
            OP_OUT:
            begin
                emitted.value     = reg_file[dst];
                emitted.div_error = div_zero_seen;
                out_words_due.push_back(emitted);
            end
            OP_MOV: reg_file[dst] = reg_file[src_a];
            OP_ADD: reg_file[dst] = lhs + rhs;
            OP_SUB: reg_file[dst] = lhs - rhs;
            OP_MUL: reg_file[dst] = lhs * rhs;
            OP_DIV:
            begin
                // zero divisor: keep the destination, latch the error
                if (rhs == '0)
                    div_zero_seen = 1'b1;
                else
                    reg_file[dst] = quotient_toward_zero(lhs, rhs);
            end
            default: ;
        endcase
    endfunction

    task automatic check_out_word(input word_t value, input logic div_error);
        out_word_t exp_word;
        out_words_seen++;
        if (out_words_due.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("ERROR out word %0d unexpected: value %h div_error %b",
                         out_words_seen, value, div_error);
        end
        else
        begin
            exp_word = out_words_due.pop_front();
            if (value !== exp_word.value || div_error !== exp_word.div_error)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("ERROR out word %0d: expected %h err %b, got %h err %b",
                             out_words_seen, exp_word.value, exp_word.div_error,
                             value, div_error);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                reg_file[i] = '0;
            div_zero_seen = 1'b0;
            out_words_due.delete();
        end
        else
        begin
            // retire output first: an OUT never leaves in the cycle it is taken
            if (m_axis_tvalid && m_axis_tready)
                check_out_word(m_axis_tdata[WORD_W-1:0], m_axis_tdata[WORD_W]);
            if (s_axis_tvalid && s_axis_tready)
                execute_instruction(s_axis_tuser[2:0], s_axis_tuser[3],
                                    s_axis_tdata[1:0], s_axis_tdata[3:2],
                                    s_axis_tdata[5:4], s_axis_tdata[37:6]);
        end
        pending_count = out_words_due.size();
    end

endmodule

/* sim/tb.sv */
// Testbench top: clock, reset, instruction stimulus, output back-pressure and verdict.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import frai_pkg::*;

    localparam logic [2:0] OP_UNUSED    = 3'd7;
    localparam idx_t       REG_A        = 2'd0;
    localparam idx_t       REG_B        = 2'd1;
    localparam idx_t       REG_C        = 2'd2;
    localparam idx_t       REG_D        = 2'd3;
    localparam int         RANDOM_ITEMS = 1700;
    localparam int         LONG_HOLD    = 400;
    localparam int         DRAIN_CYCLES = 100;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int mismatch_count;
    int pending_count;
    int burst_left     = 8;
    bit long_hold_req  = 1'b0;

    always #2 clk = ~clk;

    four_register_alu_interpreter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    four_register_alu_interpreter_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Offer one instruction word and hold it until taken; idle between bursts.
    task automatic send_instr(input logic [2:0] op, input logic three, input idx_t dst,
                              input idx_t src_a, input idx_t src_b,
                              input logic [IMM_W-1:0] imm);
        s_axis_tuser  <= {three, op};
        s_axis_tdata  <= {{(IN_DATA_W-3*REG_IDX_W-IMM_W){1'b0}}, imm, src_b, src_a, dst};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic send_random_instr();
        int               pick;
        logic [2:0]       op;
        logic [IMM_W-1:0] imm;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            op = OP_IN;
        else if (pick < 45)
            op = OP_OUT;
        else if (pick < 53)
            op = OP_MOV;
        else if (pick < 65)
            op = OP_ADD;
        else if (pick < 77)
            op = OP_SUB;
        else if (pick < 88)
            op = OP_MUL;
        else if (pick < 99)
            op = OP_DIV;
        else
            op = OP_UNUSED;
        case ($urandom_range(0, 7))
            0:       imm = '0;
            1:       imm = 32'h7FFF_FFFF;
            2:       imm = 32'h8000_0000;
            3:       imm = 32'hFFFF_FFFF;
            4:       imm = IMM_W'($signed($urandom_range(0, 31)) - 16);
            default: imm = $urandom;
        endcase
        send_instr(op, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), imm);
    endtask

    // Output side: changing stall patterns plus one long hold-off.
    initial
    begin
        int cyc;
        int mode;
        bit hold_done;
        cyc       = 0;
        mode      = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 150 == 0)
                mode = $urandom_range(0, 3);
            if (long_hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end
            else
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default: m_axis_tready <= ((cyc % 5) < 2);
                endcase
        end
    end

    initial
    begin
        #3_000_000;
        $display("four_register_alu_interpreter: mismatch");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // extremes of the immediate, then a zero divisor
        send_instr(OP_IN, 1'b0, REG_A, REG_D, REG_C, 32'h7FFF_FFFF);
        send_instr(OP_IN, 1'b1, REG_B, REG_C, REG_A, 32'h8000_0000);
        send_instr(OP_IN, 1'b0, REG_C, REG_B, REG_D, 32'hFFFF_FFFF);
        send_instr(OP_IN, 1'b0, REG_D, REG_A, REG_B, 32'h0000_0000);
        send_instr(OP_OUT, 1'b0, REG_A, REG_B, REG_C, $urandom);
        send_instr(OP_OUT, 1'b1, REG_B, REG_A, REG_D, $urandom);
        send_instr(OP_DIV, 1'b0, REG_A, REG_D, REG_B, $urandom);
        send_instr(OP_OUT, 1'b0, REG_A, REG_C, REG_C, $urandom);
        // build the most negative value and divide it by minus one
        send_instr(OP_MUL, 1'b1, REG_D, REG_B, REG_B, $urandom);
        send_instr(OP_ADD, 1'b0, REG_D, REG_D, REG_A, $urandom);
        send_instr(OP_OUT, 1'b0, REG_D, REG_A, REG_A, $urandom);
        send_instr(OP_DIV, 1'b1, REG_A, REG_D, REG_C, $urandom);
        send_instr(OP_OUT, 1'b0, REG_A, REG_B, REG_B, $urandom);
        send_instr(OP_SUB, 1'b0, REG_B, REG_C, REG_A, $urandom);
        send_instr(OP_OUT, 1'b0, REG_B, REG_D, REG_D, $urandom);
        send_instr(OP_MOV, 1'b1, REG_C, REG_D, REG_A, $urandom);
        send_instr(OP_OUT, 1'b0, REG_C, REG_A, REG_B, $urandom);
        // truncation toward zero of a negative quotient
        send_instr(OP_IN, 1'b0, REG_A, REG_B, REG_C, 32'hFFFF_FFF9);
        send_instr(OP_IN, 1'b0, REG_B, REG_A, REG_C, 32'h0000_0002);
        send_instr(OP_DIV, 1'b1, REG_C, REG_A, REG_B, $urandom);
        send_instr(OP_OUT, 1'b0, REG_C, REG_A, REG_A, $urandom);
        send_instr(OP_UNUSED, 1'b1, REG_C, REG_A, REG_B, $urandom);
        send_instr(OP_OUT, 1'b0, REG_C, REG_D, REG_D, $urandom);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 200)
                long_hold_req = 1'b1;
            send_random_instr();
        end

        if (s_axis_tvalid)
            s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("four_register_alu_interpreter: match");
        else
            $display("four_register_alu_interpreter: mismatch");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/frai_pkg.sv
rtl/core/frai_ctrl.sv
rtl/core/frai_dp.sv
rtl/core/four_register_alu_interpreter.sv
sim/four_register_alu_interpreter_checker.sv
sim/tb.sv
